// ===== hw/rtl/fbt_pkg.sv =====
package fbt_pkg;

  localparam logic [2:0] REQ_CHAR   = 3'd0;
  localparam logic [2:0] REQ_PIXEL  = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam logic [7:0] TEXT_COLUMNS = 8'd21;
  localparam int CELL_WIDTH = 6;
  localparam int GLYPH_WIDTH = 5;
  localparam int GLYPH_COUNT = 42;

  localparam logic [5:0] GLYPH_SPACE      = 6'd0;
  localparam logic [5:0] GLYPH_LETTER_A   = 6'd1;
  localparam logic [5:0] GLYPH_DIGIT_ZERO = 6'd27;
  localparam logic [5:0] GLYPH_COLON      = 6'd37;
  localparam logic [5:0] GLYPH_MINUS      = 6'd38;
  localparam logic [5:0] GLYPH_STAR       = 6'd39;
  localparam logic [5:0] GLYPH_DOT        = 6'd40;
  localparam logic [5:0] GLYPH_SLASH      = 6'd41;

  typedef logic [5:0] glyph_idx_t;
  typedef logic [2:0] cell_step_t;

endpackage

// ===== hw/rtl/fbt_glyph_rom.sv =====
module fbt_glyph_rom
  import fbt_pkg::*;
(
  input  logic [7:0] char_code,
  input  cell_step_t column,
  output logic [7:0] glyph_byte
);

  function automatic glyph_idx_t glyph_of(input logic [7:0] code);
    glyph_idx_t idx;
    idx = GLYPH_SPACE;
    if (code >= 8'h41 && code <= 8'h5A) begin
      idx = GLYPH_LETTER_A + 6'(code - 8'h41);
    end else if (code >= 8'h30 && code <= 8'h39) begin
      idx = GLYPH_DIGIT_ZERO + 6'(code - 8'h30);
    end else if (code == 8'h3A) begin
      idx = GLYPH_COLON;
    end else if (code == 8'h2D) begin
      idx = GLYPH_MINUS;
    end else if (code == 8'h2A) begin
      idx = GLYPH_STAR;
    end else if (code == 8'h2E) begin
      idx = GLYPH_DOT;
    end else if (code == 8'h2F) begin
      idx = GLYPH_SLASH;
    end
    return idx;
  endfunction

  // The leftmost glyph column sits in the top byte of each row.
  function automatic logic [39:0] glyph_row(input glyph_idx_t idx);
    logic [39:0] row;
    unique case (idx)
      6'd1:  row = 40'h7E1111117E;
      6'd2:  row = 40'h7F49494936;
      6'd3:  row = 40'h3E41414122;
      6'd4:  row = 40'h7F4141221C;
      6'd5:  row = 40'h7F49494941;
      6'd6:  row = 40'h7F09090901;
      6'd7:  row = 40'h3E4149497A;
      6'd8:  row = 40'h7F0808087F;
      6'd9:  row = 40'h00417F4100;
      6'd10: row = 40'h2040413F01;
      6'd11: row = 40'h7F08142241;
      6'd12: row = 40'h7F40404040;
      6'd13: row = 40'h7F020C027F;
      6'd14: row = 40'h7F0408107F;
      6'd15: row = 40'h3E4141413E;
      6'd16: row = 40'h7F09090906;
      6'd17: row = 40'h3E4151215E;
      6'd18: row = 40'h7F09192946;
      6'd19: row = 40'h4649494931;
      6'd20: row = 40'h01017F0101;
      6'd21: row = 40'h3F4040403F;
      6'd22: row = 40'h1F2040201F;
      6'd23: row = 40'h3F4038403F;
      6'd24: row = 40'h6314081463;
      6'd25: row = 40'h0708700807;
      6'd26: row = 40'h6151494543;
      6'd27: row = 40'h3E5149453E;
      6'd28: row = 40'h00427F4000;
      6'd29: row = 40'h4261514946;
      6'd30: row = 40'h2141454B31;
      6'd31: row = 40'h1814127F10;
      6'd32: row = 40'h2745454539;
      6'd33: row = 40'h3C4A494930;
      6'd34: row = 40'h0171090503;
      6'd35: row = 40'h3649494936;
      6'd36: row = 40'h064949291E;
      6'd37: row = 40'h0036360000;
      6'd38: row = 40'h0808080808;
      6'd39: row = 40'h14083E0814;
      6'd40: row = 40'h0060600000;
      6'd41: row = 40'h2010080402;
      default: row = 40'h0000000000;
    endcase
    return row;
  endfunction

  logic [39:0] row;

  assign row = glyph_row(glyph_of(char_code));

  always_comb begin
    unique case (column)
      3'd0: glyph_byte = row[39:32];
      3'd1: glyph_byte = row[31:24];
      3'd2: glyph_byte = row[23:16];
      3'd3: glyph_byte = row[15:8];
      3'd4: glyph_byte = row[7:0];
      default: glyph_byte = 8'h00;
    endcase
  end

endmodule

// ===== hw/rtl/framebuffer_text_pixel_engine_unit.sv =====
// Channel | Direction | Handshake          | Contents
// s       | in        | s_tvalid, s_tready | request: s_tuser kind, s_tdata operands
// m       | out       | m_tvalid, m_tready | result: read byte and cursor after request
//
// One request is in work at a time; the frame store has a single byte-wide port.
// From acceptance to a valid result, write-char makes 6 byte writes, draw-pixel does a
// memory read, then a write-back, and read a memory read, then a capture; set-cursor,
// clear, unknown kinds and ignored pixel or read requests load their result on acceptance.
// s_tready returns once the engine is idle and the result has moved to the output register.
// Clear holds s_tready low while the store is swept to zero, and after reset the same sweep
// runs before the first transaction is taken.
// A finished result waits in the output register while the next request is taken; a
// second result held back by a low m_tready keeps s_tready low.
module framebuffer_text_pixel_engine_unit
  import fbt_pkg::*;
#(
  parameter int DISPLAY_WIDTH = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int PAGE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // char_code, pos_x, pos_y, pixel_on, read_address, zeros
  input  logic [2:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // read_data, cursor_column, cursor_row_page
);

  localparam int STORE_SIZE = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int AW = $clog2(STORE_SIZE);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_CHAR   = 3'd2;
  localparam logic [2:0] S_PIX_RD = 3'd3;
  localparam logic [2:0] S_PIX_WR = 3'd4;
  localparam logic [2:0] S_RD_RD  = 3'd5;
  localparam logic [2:0] S_RD_OUT = 3'd6;

  logic [2:0]  req_type;
  logic [7:0]  char_code;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic        pixel_on;
  logic [9:0]  read_address;

  assign req_type     = s_tuser;
  assign char_code    = s_tdata[7:0];
  assign pos_x        = s_tdata[15:8];
  assign pos_y        = s_tdata[23:16];
  assign pixel_on     = s_tdata[24];
  assign read_address = s_tdata[34:25];

  logic [2:0]    state;
  logic          pend;
  logic [7:0]    res_rdata;
  logic [7:0]    text_column;
  logic [7:0]    text_page;
  cell_step_t    step;
  logic [7:0]    char_base;
  logic [7:0]    char_code_q;
  logic [AW-1:0] op_addr;
  logic [2:0]    op_bit;
  logic          op_on;
  logic [AW-1:0] clr_addr;

  logic [7:0]    mem [STORE_SIZE];
  logic [7:0]    mem_q;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata;

  logic          accept;
  logic          wrap;
  logic [7:0]    col_wrapped;
  logic [7:0]    page_inc;
  logic [7:0]    page_wrapped;
  logic [8:0]    char_pcol;
  logic          char_we;
  logic [AW-1:0] char_addr;
  logic [7:0]    glyph_byte;
  logic          pix_ok;
  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;

  assign s_tready = (state == S_IDLE) && !pend;
  assign accept   = s_tvalid && s_tready;

  assign wrap         = text_column >= TEXT_COLUMNS;
  assign col_wrapped  = wrap ? 8'd0 : text_column;
  assign page_inc     = wrap ? text_page + 8'd1 : text_page;
  assign page_wrapped = (int'(page_inc) >= PAGE_COUNT) ? 8'd0 : page_inc;

  assign char_pcol = {1'b0, char_base} + 9'(step);
  assign char_we   = int'(char_pcol) < DISPLAY_WIDTH;
  assign char_addr = AW'(int'(text_page) * DISPLAY_WIDTH + int'(char_pcol));

  assign pix_ok = (int'(pos_x) < DISPLAY_WIDTH) && (int'(pos_y) < DISPLAY_HEIGHT)
                  && (int'(pos_y[7:3]) < PAGE_COUNT);
  assign pix_addr = AW'(int'(pos_y[7:3]) * DISPLAY_WIDTH + int'(pos_x));
  assign pix_mask = 8'(1) << op_bit;

  fbt_glyph_rom u_glyph_rom (
    .char_code  (char_code_q),
    .column     (step),
    .glyph_byte (glyph_byte)
  );

  always_comb begin
    mem_addr  = op_addr;
    mem_we    = 1'b0;
    mem_wdata = 8'h00;
    unique case (state)
      S_CLEAR: begin
        mem_addr = clr_addr;
        mem_we   = 1'b1;
      end
      S_CHAR: begin
        mem_addr  = char_addr;
        mem_we    = char_we;
        mem_wdata = glyph_byte;
      end
      S_PIX_WR: begin
        mem_we    = 1'b1;
        mem_wdata = op_on ? (mem_q | pix_mask) : (mem_q & ~pix_mask);
      end
      default: begin
        mem_addr = op_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      pend        <= 1'b0;
      m_tvalid    <= 1'b0;
      text_column <= 8'd0;
      text_page   <= 8'd0;
      step        <= '0;
    end else begin
      if (pend && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {text_page, text_column, res_rdata};
        pend     <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_rdata <= 8'h00;
            unique case (req_type)
              REQ_CHAR: begin
                text_column <= col_wrapped + 8'd1;
                text_page   <= page_wrapped;
                char_base   <= 8'({col_wrapped, 2'b00} + {1'b0, col_wrapped, 1'b0});
                char_code_q <= char_code;
                step        <= '0;
                state       <= S_CHAR;
              end
              REQ_PIXEL: begin
                op_addr <= pix_addr;
                op_bit  <= pos_y[2:0];
                op_on   <= pixel_on;
                if (pix_ok) begin
                  state <= S_PIX_RD;
                end else begin
                  pend <= 1'b1;
                end
              end
              REQ_CURSOR: begin
                text_column <= pos_x;
                text_page   <= pos_y;
                pend        <= 1'b1;
              end
              REQ_CLEAR: begin
                text_column <= 8'd0;
                text_page   <= 8'd0;
                clr_addr    <= '0;
                pend        <= 1'b1;
                state       <= S_CLEAR;
              end
              REQ_READ: begin
                op_addr <= AW'(read_address);
                if (int'(read_address) < STORE_SIZE) begin
                  state <= S_RD_RD;
                end else begin
                  pend <= 1'b1;
                end
              end
              default: begin
                pend <= 1'b1;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(STORE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_CHAR: begin
          step <= step + 3'd1;
          if (int'(step) == CELL_WIDTH - 1) begin
            pend  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_PIX_RD: begin
          state <= S_PIX_WR;
        end
        S_PIX_WR: begin
          pend  <= 1'b1;
          state <= S_IDLE;
        end
        S_RD_RD: begin
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          res_rdata <= mem_q;
          pend      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_char_write_in_store: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHAR && mem_we) |-> (int'(mem_addr) < STORE_SIZE))
    else $error("character write outside the frame store");

  a_char_cursor_wrapped: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_CHAR) |=>
      (text_column <= TEXT_COLUMNS && int'(text_page) < PAGE_COUNT))
    else $error("cursor not wrapped after a character request");

  a_clear_cursor_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_CLEAR) |=>
      (text_column == 8'd0 && text_page == 8'd0 && state == S_CLEAR))
    else $error("clear request did not reset the cursor and start the sweep");

endmodule

// ===== tb/sv/text_engine_checker.sv =====
module text_engine_checker
  import fbt_pkg::*;
#(
  parameter int DISPLAY_WIDTH = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int PAGE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  localparam int STORE_SIZE = DISPLAY_WIDTH * PAGE_COUNT;

  // Each glyph lists its five columns from left to right, the leftmost in the top byte.
  localparam logic [39:0] FONT [GLYPH_COUNT] = '{
    40'h00_00_00_00_00,
    40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C,
    40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F,
    40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
    40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06,
    40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01,
    40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h61_51_49_45_43,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E,
    40'h00_36_36_00_00, 40'h08_08_08_08_08, 40'h14_08_3E_08_14, 40'h00_60_60_00_00,
    40'h20_10_08_04_02
  };

  typedef struct packed {
    logic [7:0] page;
    logic [7:0] column;
    logic [7:0] data;
  } screen_reply_t;

  logic [7:0]    frame_bytes [STORE_SIZE];
  logic [7:0]    text_col;
  logic [7:0]    text_page;
  screen_reply_t awaited_replies [$];

  function automatic glyph_idx_t glyph_for(input logic [7:0] code);
    if (code == " ") return GLYPH_SPACE;
    if (code >= "A" && code <= "Z") return GLYPH_LETTER_A + glyph_idx_t'(code - "A");
    if (code >= "0" && code <= "9") return GLYPH_DIGIT_ZERO + glyph_idx_t'(code - "0");
    if (code == ":") return GLYPH_COLON;
    if (code == "-") return GLYPH_MINUS;
    if (code == "*") return GLYPH_STAR;
    if (code == ".") return GLYPH_DOT;
    if (code == "/") return GLYPH_SLASH;
    return GLYPH_SPACE;
  endfunction

  function automatic screen_reply_t render_request(input logic [2:0] kind,
                                                   input logic [39:0] payload);
    logic [7:0]    code;
    logic [7:0]    x;
    logic [7:0]    y;
    logic          on;
    logic [9:0]    addr;
    glyph_idx_t    g;
    int            base;
    int            idx;
    logic [7:0]    cell_byte;
    screen_reply_t reply;
    code = payload[7:0];
    x = payload[15:8];
    y = payload[23:16];
    on = payload[24];
    addr = payload[34:25];
    reply.data = 8'h00;
    case (kind)
      REQ_CHAR: begin
        if (text_col >= TEXT_COLUMNS) begin
          text_col = 8'd0;
          text_page = text_page + 8'd1;
        end
        if (text_page >= PAGE_COUNT) text_page = 8'd0;
        g = glyph_for(code);
        base = int'(text_col) * CELL_WIDTH;
        for (int i = 0; i < CELL_WIDTH; i++) begin
          cell_byte = (i < GLYPH_WIDTH) ? FONT[g][39 - 8 * i -: 8] : 8'h00;
          idx = int'(text_page) * DISPLAY_WIDTH + base + i;
          if (base + i < DISPLAY_WIDTH && idx < STORE_SIZE) frame_bytes[idx] = cell_byte;
        end
        text_col = text_col + 8'd1;
      end
      REQ_PIXEL: begin
        if (x < DISPLAY_WIDTH && y < DISPLAY_HEIGHT && int'(y >> 3) < PAGE_COUNT) begin
          idx = int'(y >> 3) * DISPLAY_WIDTH + int'(x);
          if (idx < STORE_SIZE) begin
            if (on) frame_bytes[idx] = frame_bytes[idx] | (8'h01 << y[2:0]);
            else frame_bytes[idx] = frame_bytes[idx] & ~(8'h01 << y[2:0]);
          end
        end
      end
      REQ_CURSOR: begin
        text_col = x;
        text_page = y;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < STORE_SIZE; i++) frame_bytes[i] = 8'h00;
        text_col = 8'd0;
        text_page = 8'd0;
      end
      REQ_READ: begin
        if (addr < STORE_SIZE) reply.data = frame_bytes[addr];
      end
      default: begin
      end
    endcase
    reply.column = text_col;
    reply.page = text_page;
    return reply;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    screen_reply_t want;
    screen_reply_t got;
    if (rst) begin
      for (int i = 0; i < STORE_SIZE; i++) frame_bytes[i] = 8'h00;
      text_col = 8'd0;
      text_page = 8'd0;
      awaited_replies.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("read_data", want.data, got.data);
          check_field("cursor_column", want.column, got.column);
          check_field("cursor_row_page", want.page, got.page);
        end
      end
      if (s_tvalid && s_tready) awaited_replies.push_back(render_request(s_tuser, s_tdata));
    end
    pending = awaited_replies.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import fbt_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          calm = 1'b0;
  string       glyph_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789:-*./ ";

  always #5 clk = ~clk;

  framebuffer_text_pixel_engine_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  text_engine_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(input logic [2:0] kind, input logic [7:0] code, input logic [7:0] x,
                       input logic [7:0] y, input logic on, input logic [9:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'd0, addr, on, y, x, code};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic issue_random();
    logic [2:0] kind;
    logic [7:0] code;
    logic [7:0] x;
    logic [7:0] y;
    logic       on;
    logic [9:0] addr;
    int         r;
    r = $urandom_range(99);
    code = 8'($urandom);
    x = 8'($urandom);
    y = 8'($urandom);
    on = 1'($urandom);
    addr = 10'($urandom);
    if (r < 42) begin
      kind = REQ_CHAR;
      if ($urandom_range(9) < 7) code = glyph_chars[$urandom_range(glyph_chars.len() - 1)];
    end else if (r < 67) begin
      kind = REQ_PIXEL;
      if ($urandom_range(9) < 8) x = 8'($urandom_range(127));
      if ($urandom_range(9) < 8) y = 8'($urandom_range(63));
    end else if (r < 87) begin
      kind = REQ_READ;
    end else if (r < 94) begin
      kind = REQ_CURSOR;
      if ($urandom_range(3) != 0) begin
        x = 8'($urandom_range(22));
        y = 8'($urandom_range(8));
      end
    end else if (r < 96) begin
      kind = REQ_CLEAR;
    end else begin
      kind = REQ_READ + 3'($urandom_range(1, 3));
    end
    issue(kind, code, x, y, on, addr);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("framebuffer_text_pixel_engine_unit verification failed");
      $finish;
    end
  end

  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_CHAR;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(REQ_CHAR, "A", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, "Z", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, "0", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, "9", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, ":", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, "-", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, "*", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, ".", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, "/", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, 8'hFF, 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_READ, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_PIXEL, 8'd0, 8'd127, 8'd63, 1'b1, 10'd0);
    issue(REQ_PIXEL, 8'd0, 8'd128, 8'd0, 1'b1, 10'd0);
    issue(REQ_PIXEL, 8'd0, 8'd0, 8'd64, 1'b1, 10'd0);
    issue(REQ_READ, 8'd0, 8'd0, 8'd0, 1'b0, 10'd1023);
    issue(REQ_PIXEL, 8'd0, 8'd127, 8'd63, 1'b0, 10'd0);
    issue(REQ_CURSOR, 8'd0, 8'd20, 8'd7, 1'b0, 10'd0);
    issue(REQ_CHAR, "W", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CHAR, "X", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CURSOR, 8'd0, 8'd255, 8'd255, 1'b0, 10'd0);
    issue(REQ_CHAR, "M", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_CURSOR, 8'd0, 8'd0, 8'd200, 1'b0, 10'd0);
    issue(REQ_CHAR, "K", 8'd0, 8'd0, 1'b0, 10'd0);
    issue(REQ_READ + 3'd3, 8'hFF, 8'hFF, 8'hFF, 1'b1, 10'h3FF);
    issue(REQ_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(3) == 0);
      issue_random();
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("framebuffer_text_pixel_engine_unit verification clean");
    end else begin
      $display("framebuffer_text_pixel_engine_unit verification failed");
    end
    $finish;
  end

endmodule
